// ===== sv/triggered_waveform_averager_defines.svh =====
// Assertion macros shared by the averager modules.
`ifndef TRIGGERED_WAVEFORM_AVERAGER_DEFINES_SVH
`define TRIGGERED_WAVEFORM_AVERAGER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define TWA_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define TWA_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/twa_pkg.sv =====
`default_nettype none
package twa_pkg;

  localparam int SUM_W    = 24;
  localparam int POS_W    = 15;
  localparam int ADDR_MAX_W = 16;
  localparam int OUT_W    = 26;
  localparam int OUTPOS_W = 14;
  localparam int CODE_W   = 8;

  localparam logic [9:0] MV_TO_UV  = 10'd1000;
  localparam logic [6:0] FULL_CODE = 7'd127;
  localparam logic signed [50:0] OUT_LIMIT = 51'sd21000000;

  localparam logic [1:0] REG_KEPT   = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_RANGE  = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ADDR_MAX_W-1:0]   addr;
    logic signed [CODE_W-1:0] code;
    logic                    wend;
  } twa_cmd_t;

  typedef struct packed {
    logic               clearing;
    logic               idle;
  } twa_status_t;

  typedef struct packed {
    logic [14:0]        kept;
    logic [15:0]        count;
    logic [13:0]        range_mv;
    logic signed [7:0]  offset_pct;
  } twa_cfg_t;

endpackage
`default_nettype wire

// ===== sv/twa_ram.sv =====
`default_nettype none
module twa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/twa_queue.sv =====
`default_nettype none
`include "triggered_waveform_averager_defines.svh"
module twa_queue
  import twa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire twa_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output twa_cmd_t      head,
  output logic          empty
);

  twa_cmd_t   slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full  = (fill == 3'd4);
  assign empty = (fill == 3'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

  `TWA_ALWAYS(a_no_overflow, !(push && full), "queue written while full")
  `TWA_ALWAYS(a_no_underflow, !(pop && empty), "queue read while empty")
  `TWA_NEXT(a_fill_up, push && !pop, fill == $past(fill) + 3'd1, "fill count lost a push")

endmodule
`default_nettype wire

// ===== sv/twa_front.sv =====
`default_nettype none
module twa_front
  import twa_pkg::*;
#(
  parameter int MAX_KEPT = 16384,
  parameter int SEGMENT_QUANTUM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire twa_cfg_t    cfg,
  input  wire twa_status_t status,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [CODE_W-1:0] in_code,
  input  wire logic        full,
  output logic             push,
  output twa_cmd_t         push_cmd
);

  localparam int QW = (SEGMENT_QUANTUM > 1) ? $clog2(SEGMENT_QUANTUM) : 1;
  localparam logic [QW-1:0] QMAX = QW'(SEGMENT_QUANTUM - 1);
  localparam logic [16:0] MAXK = 17'(MAX_KEPT);

  logic [POS_W-1:0] pos;
  logic [QW-1:0]    qcnt;
  logic [15:0]      done;

  logic [16:0]      kept_eff;
  logic [15:0]      n_eff;
  logic [16:0]      pos1;
  logic [16:0]      base;
  logic             seg_end;
  logic             last_seg;
  logic             take;

  always_comb begin
    if (cfg.kept == '0) kept_eff = 17'd1;
    else if ({2'b0, cfg.kept} > MAXK) kept_eff = MAXK;
    else kept_eff = {2'b0, cfg.kept};
    n_eff    = (cfg.count == '0) ? 16'd1 : cfg.count;
    pos1     = {2'b0, pos} + 17'd1;
    base     = {2'b0, pos} - 17'(qcnt);
    seg_end  = (qcnt == QMAX) ? (kept_eff <= pos1) : (kept_eff <= base);
    last_seg = ({1'b0, done} + 17'd1) >= {1'b0, n_eff};
  end

  assign in_ready = !status.clearing && !full;
  assign take     = in_valid && in_ready;

  always_comb begin
    push_cmd.addr = ADDR_MAX_W'(pos);
    push_cmd.code = in_code;
    push_cmd.wend = (pos1 == kept_eff);
    push_cmd.op   = OP_ACC;
    push          = 1'b0;
    if ({2'b0, pos} < kept_eff) begin
      push_cmd.op = last_seg ? OP_EMIT : OP_ACC;
      push        = take;
    end else if (last_seg && ({2'b0, pos} < MAXK)) begin
      push_cmd.op = OP_CLEAR;
      push        = take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      qcnt <= '0;
      done <= '0;
    end else if (take) begin
      if (seg_end) begin
        pos  <= '0;
        qcnt <= '0;
        done <= last_seg ? 16'd0 : done + 16'd1;
      end else begin
        pos  <= pos1[POS_W-1:0];
        qcnt <= (qcnt == QMAX) ? '0 : qcnt + QW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/twa_back.sv =====
`default_nettype none
`include "triggered_waveform_averager_defines.svh"
module twa_back
  import twa_pkg::*;
#(
  parameter int MAX_KEPT = 16384
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire twa_cfg_t   cfg,
  output twa_status_t     status,
  input  wire logic       empty,
  input  wire twa_cmd_t   head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic signed [OUT_W-1:0] out_value,
  output logic [OUTPOS_W-1:0]     out_pos,
  output logic            out_end
);

  localparam int AW = $clog2(MAX_KEPT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_KEPT - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPD, S_MUL, S_PREP, S_DIV, S_OUT
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  twa_cmd_t         cmd;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] sum;

  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [23:0]      rk;
  logic [22:0]      den;
  logic [47:0]      prod;
  logic [48:0]      dividend;
  logic [48:0]      quot;
  logic [24:0]      rem;
  logic [23:0]      divisor;
  logic [5:0]       cnt;
  logic signed [25:0] offs;

  logic [24:0]      rem_sh;
  logic [24:0]      rem_sub;
  logic [15:0]      n_eff;
  logic signed [21:0] ro;
  logic signed [50:0] v;
  logic signed [50:0] v_sat;

  twa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_KEPT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(head.addr[AW-1:0]), .rdata(rdata)
  );

  assign status.clearing = (state == S_CLEAR);
  assign status.idle     = (state == S_IDLE) || (state == S_CLEAR);
  assign pop   = (state == S_IDLE) && !empty;
  assign sum   = rdata + {{(SUM_W-CODE_W){cmd.code[CODE_W-1]}}, cmd.code};
  assign n_eff = (cfg.count == '0) ? 16'd1 : cfg.count;
  assign ro    = $signed({1'b0, cfg.range_mv}) * cfg.offset_pct;
  assign rem_sh  = {rem[23:0], dividend[48]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    we    = 1'b0;
    waddr = cmd.addr[AW-1:0];
    wdata = '0;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (state == S_UPD) begin
      we    = 1'b1;
      wdata = (cmd.op == OP_ACC) ? sum : '0;
    end
    v = (neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot})) + 51'(offs);
    if (v > OUT_LIMIT) v_sat = OUT_LIMIT;
    else if (v < -OUT_LIMIT) v_sat = -OUT_LIMIT;
    else v_sat = v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty) begin
            cmd   <= head;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          neg <= sum[SUM_W-1];
          mag <= sum[SUM_W-1] ? -sum : sum;
          rk  <= 24'(cfg.range_mv * MV_TO_UV);
          den <= 23'(n_eff * FULL_CODE);
          state <= (cmd.op == OP_EMIT) ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          prod  <= mag * rk;
          offs  <= 26'(ro <<< 3) + 26'(ro <<< 1);
          state <= S_PREP;
        end
        S_PREP: begin
          dividend <= {prod, 1'b0} + 49'(den);
          divisor  <= {den, 1'b0};
          rem      <= '0;
          cnt      <= 6'd48;
          state    <= S_DIV;
        end
        S_DIV: begin
          dividend <= {dividend[47:0], 1'b0};
          if (!rem_sub[24]) begin
            rem  <= rem_sub;
            quot <= {quot[47:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[47:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_value <= v_sat[OUT_W-1:0];
            out_pos   <= cmd.addr[OUTPOS_W-1:0];
            out_end   <= cmd.wend;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TWA_ALWAYS(a_div_nonzero, state != S_DIV || divisor != '0, "zero divisor in divide")
  `TWA_ALWAYS(a_no_pop_clear, !(pop && status.clearing), "queue read during clearing")
  `TWA_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value),
            "stalled result lost")

endmodule
`default_nettype wire

// ===== sv/triggered_waveform_averager.sv =====
// Channel   | Direction | Handshake                     | Contents
// s_axis    | in        | s_axis_tvalid / s_axis_tready | converter samples
// m_axis    | out       | m_axis_tvalid / m_axis_tready | averaged microvolt values
// cfg       | in        | cfg_valid / cfg_ready         | register writes
//
// After reset the accumulator store is swept to zero, one entry a cycle, over
// all MAX_KEPT entries; no sample is taken until the sweep is finished.
// A sample that accumulates or clears passes the idle and update states; one that
// completes an average adds multiply, prepare, a 49-bit quotient divide and output.
// The input stalls while the four-entry queue is full, a waiting result is held
// in the output register, and register writes wait until the block is idle.
`default_nettype none
module triggered_waveform_averager
  import twa_pkg::*;
#(
  parameter int MAX_KEPT = 16384,
  parameter int SEGMENT_QUANTUM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] sample_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [25:0] average_microvolts, [39:26] position
  output logic             m_axis_tlast,  // waveform_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  twa_cfg_t    cfg;
  twa_status_t status;
  twa_cmd_t    push_cmd;
  twa_cmd_t    head;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic signed [OUT_W-1:0] out_value;
  logic [OUTPOS_W-1:0]     out_pos;

  // A register write is taken only while the queue is empty, the back end is
  // idle and no sample is offered, so no transfer in flight sees a change.
  assign cfg_ready = status.idle && empty && !s_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kept       <= 15'd1024;
      cfg.count      <= 16'd1000;
      cfg.range_mv   <= 14'd2500;
      cfg.offset_pct <= 8'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEPT:   cfg.kept       <= cfg_data[14:0];
        REG_COUNT:  cfg.count      <= cfg_data;
        REG_RANGE:  cfg.range_mv   <= cfg_data[13:0];
        REG_OFFSET: cfg.offset_pct <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The front tracks the position within the segment and the segment count,
  // and decides for each sample whether it is summed, emitted or clears.
  twa_front #(.MAX_KEPT(MAX_KEPT), .SEGMENT_QUANTUM(SEGMENT_QUANTUM)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .status(status),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_code(s_axis_tdata),
    .full(full), .push(push), .push_cmd(push_cmd)
  );

  twa_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  // The back owns the store and performs the scaling of completed averages.
  twa_back #(.MAX_KEPT(MAX_KEPT)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .status(status),
    .empty(empty), .head(head), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(out_value), .out_pos(out_pos), .out_end(m_axis_tlast)
  );

  assign m_axis_tdata = {out_pos, out_value};

endmodule
`default_nettype wire
